// ----- rtl/core/bgm_pkg.sv -----
// Shared types, codes and constants of the battery gauge monitor.
package bgm_pkg;

  localparam int IN_W  = 48;
  localparam int OUT_W = 48;
  localparam int DIV_STEPS = 16;

  localparam logic [1:0] HEALTH_UNKNOWN = 2'd0;
  localparam logic [1:0] HEALTH_GOOD    = 2'd1;
  localparam logic [1:0] HEALTH_DEAD    = 2'd2;
  localparam logic [1:0] HEALTH_OVER    = 2'd3;

  localparam logic [1:0] STATUS_UNKNOWN  = 2'd0;
  localparam logic [1:0] STATUS_CHARGING = 2'd1;
  localparam logic [1:0] STATUS_NOT_CHG  = 2'd2;
  localparam logic [1:0] STATUS_FULL     = 2'd3;

  localparam logic [1:0] CHARGER_OFF      = 2'd0;
  localparam logic [1:0] CHARGER_ON       = 2'd1;
  localparam logic [1:0] CHARGER_INVALID  = 2'd2;
  localparam logic [1:0] CHARGER_RESERVED = 2'd3;

  localparam logic [2:0] REG_COMP_BASE  = 3'd0;
  localparam logic [2:0] REG_SLOPE_HOT  = 3'd1;
  localparam logic [2:0] REG_SLOPE_COLD = 3'd2;
  localparam logic [2:0] REG_SLOPE_DIV  = 3'd3;
  localparam logic [2:0] REG_OVER_MV    = 3'd4;
  localparam logic [2:0] REG_DEAD_MV    = 3'd5;

  localparam logic [8:0] TEMP_OFFSET = 9'd30;
  localparam logic [9:0] TEMP_REF    = 10'd20;
  localparam logic [6:0] CAP_MAX     = 7'd100;
  localparam int         CAP_SHIFT   = 9;

  typedef struct packed {
    logic [7:0]         comp_base;
    logic signed [8:0]  slope_hot;
    logic signed [8:0]  slope_cold;
    logic [7:0]         slope_divisor;
    logic [12:0]        over_voltage_mv;
    logic [12:0]        dead_voltage_mv;
  } cfg_t;

  typedef struct packed {
    logic        start;
    logic [15:0] dividend;
    logic [7:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] quotient;
  } div_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_LAUNCH,
    ST_WAIT,
    ST_SUM,
    ST_OUT
  } state_t;

endpackage

// ----- rtl/core/bgm_regs.sv -----
// APB configuration register bank of the battery gauge monitor.
module bgm_regs (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output bgm_pkg::cfg_t      cfg
);
  import bgm_pkg::*;

  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.comp_base       <= 8'd0;
      cfg.slope_hot       <= 9'sd0;
      cfg.slope_cold      <= 9'sd0;
      cfg.slope_divisor   <= 8'd1;
      cfg.over_voltage_mv <= 13'd4300;
      cfg.dead_voltage_mv <= 13'd3000;
    end else if (wr_en) begin
      case (idx)
        REG_COMP_BASE:  cfg.comp_base       <= pwdata[7:0];
        REG_SLOPE_HOT:  cfg.slope_hot       <= $signed(pwdata[8:0]);
        REG_SLOPE_COLD: cfg.slope_cold      <= $signed(pwdata[8:0]);
        REG_SLOPE_DIV:  cfg.slope_divisor   <= pwdata[7:0];
        REG_OVER_MV:    cfg.over_voltage_mv <= pwdata[12:0];
        REG_DEAD_MV:    cfg.dead_voltage_mv <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_COMP_BASE:  prdata = {24'd0, cfg.comp_base};
      REG_SLOPE_HOT:  prdata = {23'd0, cfg.slope_hot};
      REG_SLOPE_COLD: prdata = {23'd0, cfg.slope_cold};
      REG_SLOPE_DIV:  prdata = {24'd0, cfg.slope_divisor};
      REG_OVER_MV:    prdata = {19'd0, cfg.over_voltage_mv};
      REG_DEAD_MV:    prdata = {19'd0, cfg.dead_voltage_mv};
      default:        prdata = 32'd0;
    endcase
  end

endmodule

// ----- rtl/core/bgm_div.sv -----
// Restoring serial divider that produces one quotient bit per cycle.
module bgm_div (
  input  logic                 clk,
  input  logic                 rst,
  input  bgm_pkg::div_req_t    req,
  output bgm_pkg::div_rsp_t    rsp
);
  import bgm_pkg::*;

  logic [15:0] work;
  logic [7:0]  rem;
  logic [7:0]  dvsr;
  logic [3:0]  count;
  logic        busy;
  logic        done;
  logic [8:0]  shifted;
  logic        ge;
  logic [8:0]  diff;

  assign shifted = {rem, work[15]};
  assign ge      = shifted >= {1'b0, dvsr};
  assign diff    = shifted - {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= 4'd0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= 4'd0;
      end else if (busy) begin
        count <= count + 4'd1;
        if (count == 4'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      work <= req.dividend;
      rem  <= 8'd0;
      dvsr <= req.divisor;
    end else if (busy) begin
      work <= {work[14:0], ge};
      rem  <= ge ? diff[7:0] : shifted[7:0];
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = work;

endmodule

// ----- rtl/core/bgm_core.sv -----
// Poll state update and compensation sequencer of the battery gauge monitor.
module bgm_core (
  input  logic                       clk,
  input  logic                       rst,
  input  bgm_pkg::cfg_t              cfg,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [bgm_pkg::IN_W-1:0]   s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [bgm_pkg::OUT_W-1:0]  m_axis_tdata
);
  import bgm_pkg::*;

  state_t state, state_next;

  logic [12:0]       voltage_reg, voltage_next;
  logic              present_reg, present_next;
  logic [1:0]        health_reg, health_next;
  logic signed [8:0] temperature_reg, temperature_next;
  logic [6:0]        capacity_reg, capacity_next;
  logic [1:0]        status_reg, status_next;
  logic              low_battery_latch, latch_next;
  logic              notify_pending;
  logic              notify_reg, notify_next;

  logic [15:0] in_vcell;
  logic        in_vok;
  logic [15:0] in_charge;
  logic        in_cok;
  logic [7:0]  in_thermo;
  logic        in_tok;
  logic [1:0]  in_charger;
  logic        in_event;

  logic        accept;
  logic [11:0] raw_mv;
  logic [12:0] mv;
  logic [6:0]  cap_raw;

  logic signed [9:0] delta;
  logic signed [8:0] slope;
  logic [7:0]        delta_mag;
  logic [8:0]        slope_mag;
  logic [16:0]       prod_full;
  logic [15:0]       prod;
  logic              prod_neg;
  logic              term_zero;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic signed [17:0] term;
  logic signed [17:0] acc;
  logic [7:0]         comp_value;
  logic [7:0]         comp_clamped;

  assign in_vcell   = s_axis_tdata[15:0];
  assign in_vok     = s_axis_tdata[16];
  assign in_charge  = s_axis_tdata[32:17];
  assign in_cok     = s_axis_tdata[33];
  assign in_thermo  = s_axis_tdata[41:34];
  assign in_tok     = s_axis_tdata[42];
  assign in_charger = s_axis_tdata[44:43];
  assign in_event   = s_axis_tdata[45];

  assign accept  = s_axis_tvalid & s_axis_tready;
  assign raw_mv  = in_vcell[15:4];
  assign mv      = {1'b0, raw_mv} + {3'd0, raw_mv[11:2]};
  assign cap_raw = in_charge[15:CAP_SHIFT];

  always_comb begin
    latch_next       = low_battery_latch | in_event;
    notify_next      = notify_pending | in_event;
    voltage_next     = voltage_reg;
    present_next     = present_reg;
    health_next      = health_reg;
    temperature_next = temperature_reg;
    capacity_next    = capacity_reg;
    if (in_vok) begin
      voltage_next = mv;
      present_next = mv != 13'd0;
      if (mv >= cfg.over_voltage_mv) begin
        health_next = HEALTH_OVER;
      end else if (mv <= cfg.dead_voltage_mv) begin
        health_next = HEALTH_DEAD;
      end else begin
        health_next = HEALTH_GOOD;
      end
      if (present_next != present_reg || health_next != health_reg) begin
        notify_next = 1'b1;
      end
    end
    if (in_tok) begin
      temperature_next = $signed({1'b0, in_thermo} - TEMP_OFFSET);
    end
    if (latch_next) begin
      capacity_next = 7'd0;
    end else if (in_cok) begin
      capacity_next = (cap_raw > CAP_MAX) ? CAP_MAX : cap_raw;
    end
    if (capacity_next != capacity_reg) begin
      notify_next = 1'b1;
    end
    case (in_charger)
      CHARGER_OFF: status_next = STATUS_NOT_CHG;
      CHARGER_ON:  status_next = (capacity_next >= CAP_MAX) ? STATUS_FULL : STATUS_CHARGING;
      default:     status_next = STATUS_UNKNOWN;
    endcase
    if (status_next != status_reg) begin
      notify_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      voltage_reg       <= 13'd0;
      present_reg       <= 1'b0;
      health_reg        <= HEALTH_UNKNOWN;
      temperature_reg   <= 9'sd0;
      capacity_reg      <= 7'd0;
      status_reg        <= STATUS_UNKNOWN;
      low_battery_latch <= 1'b0;
      notify_pending    <= 1'b1;
      notify_reg        <= 1'b0;
    end else if (accept) begin
      voltage_reg       <= voltage_next;
      present_reg       <= present_next;
      health_reg        <= health_next;
      temperature_reg   <= temperature_next;
      capacity_reg      <= capacity_next;
      status_reg        <= status_next;
      low_battery_latch <= latch_next;
      notify_pending    <= 1'b0;
      notify_reg        <= notify_next;
    end
  end

  assign delta     = {temperature_reg[8], temperature_reg} - TEMP_REF;
  assign slope     = (delta > 10'sd0) ? cfg.slope_hot : cfg.slope_cold;
  assign delta_mag = delta[9] ? 8'(-delta) : delta[7:0];
  assign slope_mag = slope[8] ? 9'(-slope) : slope;
  assign prod_full = {9'd0, delta_mag} * {8'd0, slope_mag};

  always_ff @(posedge clk) begin
    if (state == ST_MUL) begin
      prod      <= prod_full[15:0];
      prod_neg  <= delta[9] ^ slope[8];
      term_zero <= delta == 10'sd0;
    end
  end

  always_comb begin
    div_req.start    = state == ST_LAUNCH;
    div_req.dividend = prod;
    div_req.divisor  = (cfg.slope_divisor == 8'd0) ? 8'd1 : cfg.slope_divisor;
  end

  bgm_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_comb begin
    if (term_zero) begin
      term = 18'sd0;
    end else if (prod_neg) begin
      term = -$signed({2'b00, div_rsp.quotient});
    end else begin
      term = $signed({2'b00, div_rsp.quotient});
    end
    acc = $signed({10'd0, cfg.comp_base}) + term;
    if (acc > 18'sd255) begin
      comp_clamped = 8'd255;
    end else if (acc < 18'sd0) begin
      comp_clamped = 8'd0;
    end else begin
      comp_clamped = acc[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SUM) begin
      comp_value <= low_battery_latch ? 8'd0 : comp_clamped;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (accept) state_next = ST_MUL;
      ST_MUL:    state_next = ST_LAUNCH;
      ST_LAUNCH: state_next = ST_WAIT;
      ST_WAIT:   if (div_rsp.done) state_next = ST_SUM;
      ST_SUM:    state_next = ST_OUT;
      ST_OUT:    if (!m_axis_tvalid || m_axis_tready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    case (state)
      ST_IDLE: s_axis_tready = !rst;
      default: s_axis_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == ST_OUT && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tdata <= {4'd0, notify_reg, ~low_battery_latch, comp_value, status_reg,
                       capacity_reg, temperature_reg, health_reg, present_reg,
                       voltage_reg};
    end
  end

endmodule

// ----- rtl/core/battery_gauge_monitor_top.sv -----
// Top level of the battery gauge monitor.
// Each poll updates voltage, presence, health, temperature, capacity and charge
// status when accepted, then forms the temperature compensation byte with one
// 9 by 8 bit multiply and a restoring divider that yields one quotient bit per
// cycle, passing the multiply, launch, wait, sum and output states, with the input
// not ready, before its result is loaded into the output register. A result may
// wait there while the next poll is taken. The user must write configuration through
// the APB port only while the block is idle; the block itself does not enforce it.
module battery_gauge_monitor_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // Fields from bit 0: vcell_word[15:0], vcell_ok, charge_word[15:0], charge_ok,
  // thermo_code[7:0], thermo_ok, charger_code[1:0], low_battery_event, zero fill.
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // Fields from bit 0: voltage_mv[12:0], present, health[1:0], temperature_c[8:0],
  // capacity_pct[6:0], charge_status[1:0], comp_value[7:0], comp_write, notify,
  // zero fill.
  output logic [47:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bgm_pkg::*;

  cfg_t cfg;

  bgm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bgm_core u_core (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

// ----- dv/battery_gauge_monitor_top_test.sv -----
// Self-checking testbench for the battery gauge monitor: stream polls in, gauge readings out.
`timescale 1ns / 1ps

module battery_gauge_monitor_top_test;
  import bgm_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [1:0]  zero_fill;
    logic        low_battery_event;
    logic [1:0]  charger_code;
    logic        thermo_ok;
    logic [7:0]  thermo_code;
    logic        charge_ok;
    logic [15:0] charge_word;
    logic        vcell_ok;
    logic [15:0] vcell_word;
  } poll_t;

  typedef struct packed {
    logic [3:0]        zero_fill;
    logic              notify;
    logic              comp_write;
    logic [7:0]        comp_value;
    logic [1:0]        charge_status;
    logic [6:0]        capacity_pct;
    logic signed [8:0] temperature_c;
    logic [1:0]        health;
    logic              present;
    logic [12:0]       voltage_mv;
  } reading_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // Fields from bit 0: vcell_word[15:0], vcell_ok, charge_word[15:0], charge_ok,
  // thermo_code[7:0], thermo_ok, charger_code[1:0], low_battery_event, zero fill.
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // Fields from bit 0: voltage_mv[12:0], present, health[1:0], temperature_c[8:0],
  // capacity_pct[6:0], charge_status[1:0], comp_value[7:0], comp_write, notify,
  // zero fill.
  logic [47:0] m_axis_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  battery_gauge_monitor_top uut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Configuration as the block should hold it.
  int cfg_base = 0;
  int cfg_hot = 0;
  int cfg_cold = 0;
  int cfg_div = 1;
  int cfg_over = 4300;
  int cfg_dead = 3000;

  // Gauge state as the block should hold it.
  int g_voltage = 0;
  int g_present = 0;
  int g_health = int'(HEALTH_UNKNOWN);
  int g_temp = 0;
  int g_cap = 0;
  int g_status = int'(STATUS_UNKNOWN);
  bit g_low_latch = 1'b0;
  bit g_notify_pending = 1'b1;

  poll_t    poll_q[$];
  reading_t reading_q[$];
  poll_t    cur_poll = '0;
  int       sent_cnt = 0;
  int       taken_cnt = 0;
  int       fail_cnt = 0;
  int       cycle_cnt = 0;
  int       src_idle_max = 0;
  int       sink_idle_max = 0;
  int       src_gap = 0;
  int       sink_wait = 0;
  int       stall_ask = 0;
  int       stall_left = 0;
  bit       stall_taken = 1'b0;

  function automatic reading_t predict_poll(poll_t p);
    reading_t r;
    int mv, hl, cap, st, delta, acc, div;
    bit chg;
    r = '0;
    chg = g_notify_pending;
    if (p.low_battery_event) begin
      g_low_latch = 1'b1;
      chg = 1'b1;
    end
    if (p.vcell_ok) begin
      mv = int'(p.vcell_word) >> 4;
      mv = mv + (mv >> 2);
      if (mv >= cfg_over) hl = int'(HEALTH_OVER);
      else if (mv <= cfg_dead) hl = int'(HEALTH_DEAD);
      else hl = int'(HEALTH_GOOD);
      if (int'(mv > 0) != g_present || hl != g_health) chg = 1'b1;
      g_voltage = mv;
      g_present = int'(mv > 0);
      g_health = hl;
    end
    if (p.thermo_ok) g_temp = int'(p.thermo_code) - int'(TEMP_OFFSET);
    if (g_low_latch) begin
      if (g_cap != 0) chg = 1'b1;
      g_cap = 0;
    end else begin
      div = (cfg_div == 0) ? 1 : cfg_div;
      delta = g_temp - int'(TEMP_REF);
      acc = cfg_base;
      if (delta > 0) acc += (delta * cfg_hot) / div;
      else if (delta < 0) acc += (delta * cfg_cold) / div;
      if (acc > 255) acc = 255;
      if (acc < 0) acc = 0;
      r.comp_value = acc[7:0];
      r.comp_write = 1'b1;
      if (p.charge_ok) begin
        cap = int'(p.charge_word) >> CAP_SHIFT;
        if (cap > int'(CAP_MAX)) cap = int'(CAP_MAX);
        if (cap != g_cap) chg = 1'b1;
        g_cap = cap;
      end
    end
    if (p.charger_code == CHARGER_OFF) st = int'(STATUS_NOT_CHG);
    else if (p.charger_code == CHARGER_ON)
      st = (g_cap >= int'(CAP_MAX)) ? int'(STATUS_FULL) : int'(STATUS_CHARGING);
    else st = int'(STATUS_UNKNOWN);
    if (st != g_status) chg = 1'b1;
    g_status = st;
    g_notify_pending = 1'b0;
    r.voltage_mv = g_voltage[12:0];
    r.present = g_present[0];
    r.health = g_health[1:0];
    r.temperature_c = g_temp[8:0];
    r.capacity_pct = g_cap[6:0];
    r.charge_status = g_status[1:0];
    r.notify = chg;
    return r;
  endfunction

  function automatic poll_t mk_poll(logic [15:0] vw, logic vok, logic [15:0] cw, logic cok,
                                    logic [7:0] tc, logic tok, logic [1:0] chg, logic ev);
    poll_t p;
    p = '0;
    p.vcell_word = vw;
    p.vcell_ok = vok;
    p.charge_word = cw;
    p.charge_ok = cok;
    p.thermo_code = tc;
    p.thermo_ok = tok;
    p.charger_code = chg;
    p.low_battery_event = ev;
    return p;
  endfunction

  function automatic poll_t random_poll(bit with_event);
    poll_t p;
    int raw;
    p = '0;
    p.vcell_word = 16'($urandom);
    if ($urandom_range(0, 3) == 0) begin
      raw = ((($urandom_range(0, 1) != 0) ? cfg_over : cfg_dead) * 4) / 5
            + int'($urandom_range(0, 2)) - 1;
      if (raw < 0) raw = 0;
      if (raw > 4095) raw = 4095;
      p.vcell_word = {raw[11:0], p.vcell_word[3:0]};
    end
    p.vcell_ok = ($urandom_range(0, 4) != 0);
    p.charge_word = 16'($urandom);
    p.charge_ok = ($urandom_range(0, 4) != 0);
    p.thermo_code = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(45, 55)) : 8'($urandom);
    p.thermo_ok = ($urandom_range(0, 4) != 0);
    if ($urandom_range(0, 5) == 0) begin
      p.charger_code = ($urandom_range(0, 1) != 0) ? CHARGER_RESERVED : CHARGER_INVALID;
    end else begin
      p.charger_code = ($urandom_range(0, 1) != 0) ? CHARGER_ON : CHARGER_OFF;
    end
    p.low_battery_event = with_event && ($urandom_range(0, 19) == 0);
    return p;
  endfunction

  task automatic check_field(string name, logic signed [31:0] want, logic signed [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_cnt++;
    end
  endtask

  task automatic queue_poll(poll_t p);
    poll_q.push_back(p);
    sent_cnt++;
  endtask

  task automatic wait_idle();
    while (taken_cnt != sent_cnt || reading_q.size() != 0) @(posedge clk);
  endtask

  task automatic apb_write(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_COMP_BASE:  cfg_base = int'(val[7:0]);
      REG_SLOPE_HOT:  cfg_hot = int'($signed(val[8:0]));
      REG_SLOPE_COLD: cfg_cold = int'($signed(val[8:0]));
      REG_SLOPE_DIV:  cfg_div = int'(val[7:0]);
      REG_OVER_MV:    cfg_over = int'(val[12:0]);
      REG_DEAD_MV:    cfg_dead = int'(val[12:0]);
      default: ;
    endcase
  endtask

  task automatic apply_config(int base, int hot, int cold, int div, int over, int dead);
    apb_write(REG_COMP_BASE, 32'(base));
    apb_write(REG_SLOPE_HOT, 32'(hot));
    apb_write(REG_SLOPE_COLD, 32'(cold));
    apb_write(REG_SLOPE_DIV, 32'(div));
    apb_write(REG_OVER_MV, 32'(over));
    apb_write(REG_DEAD_MV, 32'(dead));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        reading_q.push_back(predict_poll(cur_poll));
        taken_cnt++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (poll_q.size() != 0) begin
          cur_poll = poll_q.pop_front();
          src_gap = int'($urandom_range(0, src_idle_max));
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= cur_poll;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    reading_t want, got;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (reading_q.size() == 0) begin
          $error("reading beat with no poll pending: %h", m_axis_tdata);
          fail_cnt++;
        end else begin
          want = reading_q.pop_front();
          check_field("voltage_mv", 32'(want.voltage_mv), 32'(got.voltage_mv));
          check_field("present", 32'(want.present), 32'(got.present));
          check_field("health", 32'(want.health), 32'(got.health));
          check_field("temperature_c", 32'(want.temperature_c), 32'(got.temperature_c));
          check_field("capacity_pct", 32'(want.capacity_pct), 32'(got.capacity_pct));
          check_field("charge_status", 32'(want.charge_status), 32'(got.charge_status));
          check_field("comp_value", 32'(want.comp_value), 32'(got.comp_value));
          check_field("comp_write", 32'(want.comp_write), 32'(got.comp_write));
          check_field("notify", 32'(want.notify), 32'(got.notify));
        end
        sink_wait = int'($urandom_range(0, sink_idle_max));
      end
      if (stall_ask != 0 && !stall_taken) begin
        stall_left = stall_ask;
        stall_taken = 1'b1;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (sink_wait > 0) begin
        sink_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("battery_gauge_monitor_top verification failed");
      $finish;
    end
  end

  initial begin
    int ph, i, base, hot, cold, div, over;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    apply_config(128, 200, -150, 7, 4300, 3000);
    queue_poll(mk_poll(16'h0000, 1'b1, 16'h0000, 1'b1, 8'd0, 1'b1, CHARGER_OFF, 1'b0));
    queue_poll(mk_poll(16'hFFFF, 1'b1, 16'hFFFF, 1'b1, 8'd255, 1'b1, CHARGER_ON, 1'b0));
    queue_poll(mk_poll(16'h0010, 1'b1, 16'h0000, 1'b1, 8'd50, 1'b1, CHARGER_ON, 1'b0));
    queue_poll(mk_poll(16'd3440 << 4, 1'b1, 16'd99 << 9, 1'b1, 8'd51, 1'b1, CHARGER_ON,
                       1'b0));
    queue_poll(mk_poll(16'd2400 << 4, 1'b1, 16'd100 << 9, 1'b1, 8'd49, 1'b1, CHARGER_ON,
                       1'b0));
    queue_poll(mk_poll(16'd2401 << 4, 1'b1, 16'd101 << 9, 1'b1, 8'd20, 1'b1,
                       CHARGER_INVALID, 1'b0));
    queue_poll(mk_poll(16'd3439 << 4 | 16'hF, 1'b1, 16'h1FF, 1'b1, 8'd90, 1'b1,
                       CHARGER_RESERVED, 1'b0));
    queue_poll(mk_poll(16'hFFFF, 1'b0, 16'hFFFF, 1'b0, 8'hFF, 1'b0, CHARGER_OFF, 1'b0));
    queue_poll(mk_poll(16'h0000, 1'b0, 16'h0000, 1'b0, 8'h00, 1'b0, CHARGER_ON, 1'b0));
    queue_poll(mk_poll(16'h0000, 1'b1, 16'hFE00, 1'b1, 8'd30, 1'b1, CHARGER_ON, 1'b0));
    queue_poll(mk_poll(16'h5555, 1'b1, 16'hAAAA, 1'b1, 8'h55, 1'b1, CHARGER_RESERVED,
                       1'b0));
    queue_poll(mk_poll(16'hAAAA, 1'b1, 16'h5555, 1'b1, 8'hAA, 1'b1, CHARGER_OFF, 1'b0));
    wait_idle();

    for (ph = 0; ph < 7; ph++) begin
      case (ph)
        0: apply_config(0, -255, 255, 255, 4300, 3000);
        1: apply_config(255, 255, -255, 1, 0, 8191);
        2: apply_config(100, 37, -11, 0, 8191, 0);
        default: begin
          base = int'($urandom_range(0, 255));
          hot = int'($urandom_range(0, 510)) - 255;
          cold = int'($urandom_range(0, 510)) - 255;
          div = int'($urandom_range(1, 255));
          over = int'($urandom_range(3500, 5118));
          apply_config(base, hot, cold, div, over, int'($urandom_range(0, over)));
        end
      endcase
      src_idle_max = (ph % 2 == 1) ? 9 : 0;
      sink_idle_max = (ph % 3 == 1) ? 0 : 9;
      if (ph == 4) stall_ask = 400;
      for (i = 0; i < 200; i++) queue_poll(random_poll(1'b0));
      wait_idle();
    end

    // The low battery latch is sticky, so it is exercised last.
    src_idle_max = 9;
    sink_idle_max = 9;
    apply_config(60, -90, 120, 3, 4200, 3300);
    queue_poll(mk_poll(16'h9000, 1'b1, 16'hC800, 1'b1, 8'd70, 1'b1, CHARGER_ON, 1'b0));
    queue_poll(mk_poll(16'h9000, 1'b1, 16'hC800, 1'b1, 8'd70, 1'b1, CHARGER_ON, 1'b1));
    queue_poll(mk_poll(16'h9000, 1'b1, 16'hFFFF, 1'b1, 8'd10, 1'b1, CHARGER_ON, 1'b0));
    queue_poll(mk_poll(16'h9000, 1'b1, 16'hFFFF, 1'b1, 8'd10, 1'b1, CHARGER_OFF, 1'b1));
    for (i = 0; i < 100; i++) queue_poll(random_poll(1'b1));
    wait_idle();

    repeat (40) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("battery_gauge_monitor_top verification clean");
    end else begin
      $display("battery_gauge_monitor_top verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/bgm_pkg.sv
rtl/core/bgm_regs.sv
rtl/core/bgm_div.sv
rtl/core/bgm_core.sv
rtl/core/battery_gauge_monitor_top.sv
dv/battery_gauge_monitor_top_test.sv
